// ===== design/pihm_pkg.sv =====
package pihm_pkg;

	localparam int CHANNELS_DEF     = 4;
	localparam int WINDOW_DEPTH_DEF = 16;

	// shared iterative divider geometry
	localparam int DVD_W = 64;
	localparam int DVS_W = 32;
	localparam int DCNT_W = $clog2(DVD_W);

	// square root: 64-bit radicand, one result bit per cycle
	localparam int SQ_STEPS = DVD_W / 2;
	localparam int SCNT_W   = $clog2(SQ_STEPS);

	localparam logic [15:0] UNCAL_RATE_RST  = 16'd7200;
	localparam logic [31:0] STUCK_TMO_RST   = 32'd60000;
	localparam logic [15:0] NOISE_LIM_RST   = 16'd205;
	localparam logic [6:0]  MIN_SCORE_RST   = 7'd70;

	localparam logic [14:0] CAL_QUALITY   = 15'd12800;
	localparam logic [14:0] STUCK_QUALITY = 15'd2560;
	localparam logic [14:0] SCORE_FULL    = 15'd25600;
	localparam logic [5:0]  PEN_WEIGHT    = 6'd20;
	localparam logic [31:0] FLOW_NUM      = 32'd16384000;
	localparam logic [15:0] FLOW_MAX      = 16'hFFFF;

	typedef enum logic [1:0] {
		CFG_UNCAL_RATE = 2'd0,
		CFG_STUCK_TMO  = 2'd1,
		CFG_NOISE_LIM  = 2'd2,
		CFG_MIN_SCORE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_PULSE = 2'd0,
		REQ_NOISE = 2'd1,
		REQ_TICK  = 2'd2
	} req_code_t;

	typedef enum logic [2:0] {
		HEALTH_GOOD   = 3'd0,
		HEALTH_NOISY  = 3'd1,
		HEALTH_STUCK  = 3'd2,
		HEALTH_NOSIG  = 3'd3,
		HEALTH_CALIB  = 3'd4
	} health_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REC,
		ST_PULSE_OLD,
		ST_PULSE_MUL,
		ST_PULSE_VAR,
		ST_MEAN_DIV,
		ST_MEAN_WAIT,
		ST_VAR_DIV,
		ST_VAR_WAIT,
		ST_SQRT_RUN,
		ST_FLOW_MUL,
		ST_FLOW_DIV,
		ST_FLOW_WAIT,
		ST_TICK_CHK,
		ST_RATIO_DIV,
		ST_RATIO_WAIT,
		ST_SCORE_MUL,
		ST_SCORE_DIV,
		ST_SCORE_WAIT,
		ST_TICK_CLASS,
		ST_DONE
	} state_t;

endpackage

// ===== design/pihm_if.sv =====
interface pihm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [1:0]  channel;
	logic [15:0] interval_ms;
	logic [15:0] pulses_per_oz;
	logic        pouring;
	logic [31:0] pour_elapsed_ms;

	modport source (output valid, req_type, channel, interval_ms, pulses_per_oz,
		pouring, pour_elapsed_ms, input ready);
	modport sink (input valid, req_type, channel, interval_ms, pulses_per_oz,
		pouring, pour_elapsed_ms, output ready);
endinterface

interface pihm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_channel;
	logic [2:0]  health;
	logic [14:0] quality;
	logic [19:0] mean_interval;
	logic [19:0] interval_spread;
	logic [15:0] flow_rate;
	logic [31:0] good_pulses;
	logic [31:0] rejected_pulses;

	modport source (output valid, out_channel, health, quality, mean_interval,
		interval_spread, flow_rate, good_pulses, rejected_pulses, input ready);
	modport sink (input valid, out_channel, health, quality, mean_interval,
		interval_spread, flow_rate, good_pulses, rejected_pulses, output ready);
endinterface

// ===== design/pulse_interval_health_monitor.sv =====
// Work per request: a noise request only bumps its rejected count;
//   a health tick takes up to two 64-step divider passes (ratio, score);
//   a valid pulse takes up to three divider passes plus a 32-step square root, and
//   only the mean and flow passes while the window holds fewer than two entries.
// Throughput: one request at a time; the next request can be taken in the cycle after
//   the current one has been handed to the output register.
// Reset (arst_n low): config registers to defaults, all channel records read as
//   reset values through per-channel valid bits; window memory is not cleared.
module pulse_interval_health_monitor #(
	parameter int CHANNELS     = pihm_pkg::CHANNELS_DEF,
	parameter int WINDOW_DEPTH = pihm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pihm_req_if.sink    req,
	pihm_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = 16 + FILL_W;
	localparam int SQ_W   = 32 + FILL_W;
	localparam int NSQ_W  = SQ_W + FILL_W;
	localparam int S2_W   = 2 * SUM_W;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WA_W   = $clog2(CHANNELS * WINDOW_DEPTH);
	localparam int WENT   = CHANNELS * WINDOW_DEPTH;

	// per-channel record, one memory word
	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [SLOT_W-1:0] slot;
		logic [SUM_W-1:0]  sum;
		logic [SQ_W-1:0]   sq;
		logic [19:0]       mean;
		logic [19:0]       spread;
		logic [15:0]       flow;
		logic [31:0]       good;
		logic [31:0]       rej;
		logic [2:0]        health;
		logic [14:0]       quality;
	} chan_rec_t;

	localparam chan_rec_t REC_RESET = '{
		fill: '0, slot: '0, sum: '0, sq: '0, mean: '0, spread: '0, flow: '0,
		good: '0, rej: '0, health: pihm_pkg::HEALTH_NOSIG, quality: '0};

	// configuration
	logic [15:0] uncal_rate_q;
	logic [31:0] stuck_tmo_q;
	logic [15:0] noise_lim_q;
	logic [6:0]  min_score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uncal_rate_q <= pihm_pkg::UNCAL_RATE_RST;
			stuck_tmo_q  <= pihm_pkg::STUCK_TMO_RST;
			noise_lim_q  <= pihm_pkg::NOISE_LIM_RST;
			min_score_q  <= pihm_pkg::MIN_SCORE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pihm_pkg::CFG_UNCAL_RATE: uncal_rate_q <= cfg_data[15:0];
				pihm_pkg::CFG_STUCK_TMO:  stuck_tmo_q  <= cfg_data;
				pihm_pkg::CFG_NOISE_LIM:  noise_lim_q  <= cfg_data[15:0];
				pihm_pkg::CFG_MIN_SCORE:  min_score_q  <= cfg_data[6:0];
			endcase
		end
	end

	pihm_pkg::state_t state_q, state_d;

	// control decoded from state
	logic                     acc;
	logic                     req_ok;
	logic                     dv_start;
	logic [pihm_pkg::DVD_W-1:0] dv_dvd;
	logic [pihm_pkg::DVS_W-1:0] dv_dvs;
	logic                     sq_start;
	logic                     win_we;
	logic                     done_go;

	// request latch
	logic [1:0]  type_q;
	logic [1:0]  ch_q;
	logic [15:0] iv_q;
	logic [15:0] ppo_q;
	logic        pour_q;
	logic [31:0] elapsed_q;

	// channel record memory and its valid bits
	chan_rec_t           chan_mem [CHANNELS];
	chan_rec_t           chan_rd_q;
	logic                rd_vld_q;
	logic [CHANNELS-1:0] rec_vld_q;
	chan_rec_t           cur_rec;
	chan_rec_t           rec_init;
	chan_rec_t           rec_q;
	logic [CH_W-1:0]     rd_idx;
	logic [CH_W-1:0]     ch_idx;

	// window memory
	logic [15:0]     win_mem [WENT];
	logic [15:0]     win_rd_q;
	logic [WA_W-1:0] win_addr;
	logic [WA_W-1:0] win_addr_q;

	// arithmetic holding registers
	logic [NSQ_W-1:0] nsq_q;
	logic [S2_W-1:0]  s2_q;
	logic [NSQ_W-1:0] d_q;
	logic [2*FILL_W-1:0] nn_q;
	logic [31:0]      prod_q;
	logic [27:0]      ratio_q;
	logic [46:0]      sm_q;
	logic [14:0]      score_q;
	logic [31:0]      old_sq;
	logic [31:0]      new_sq;
	logic [32:0]      pen;

	// divider
	logic                         dv_busy_q;
	logic [pihm_pkg::DCNT_W-1:0]  dv_cnt_q;
	logic [pihm_pkg::DVD_W-1:0]   dv_num_q;
	logic [pihm_pkg::DVS_W-1:0]   dv_rem_q;
	logic [pihm_pkg::DVS_W-1:0]   dv_den_q;
	logic [pihm_pkg::DVS_W:0]     dv_sh;
	logic                         dv_fit;

	// square root
	logic                         sq_busy_q;
	logic [pihm_pkg::SCNT_W-1:0]  sq_cnt_q;
	logic [pihm_pkg::DVD_W-1:0]   sq_x_q;
	logic [33:0]                  sq_rem_q;
	logic [31:0]                  sq_root_q;
	logic [33:0]                  sq_sh;
	logic [33:0]                  sq_trial;

	// output register
	logic        out_vld_q;
	chan_rec_t   out_rec_q;
	logic [1:0]  out_ch_q;

	assign req_ok = (req.req_type == pihm_pkg::REQ_PULSE || req.req_type == pihm_pkg::REQ_NOISE
		|| req.req_type == pihm_pkg::REQ_TICK) && (32'(req.channel) < CHANNELS);
	assign acc    = req.valid && req.ready;
	assign rd_idx = CH_W'(req.channel);
	assign ch_idx = CH_W'(ch_q);
	assign cur_rec = rd_vld_q ? chan_rd_q : REC_RESET;
	assign win_addr = WA_W'(int'(ch_idx) * WINDOW_DEPTH + int'(cur_rec.slot));
	assign old_sq = 32'(win_rd_q) * 32'(win_rd_q);
	assign new_sq = 32'(iv_q) * 32'(iv_q);
	assign pen    = 33'(ratio_q) * 33'(pihm_pkg::PEN_WEIGHT);

	// record as loaded: counters bumped, saturating
	always_comb begin
		rec_init = cur_rec;
		if (type_q == pihm_pkg::REQ_PULSE && cur_rec.good != '1)
			rec_init.good = cur_rec.good + 1'b1;
		if (type_q == pihm_pkg::REQ_NOISE && cur_rec.rej != '1)
			rec_init.rej = cur_rec.rej + 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pihm_pkg::ST_IDLE:      if (acc && req_ok) state_d = pihm_pkg::ST_REC;
			pihm_pkg::ST_REC: begin
				unique case (type_q)
					pihm_pkg::REQ_PULSE: state_d = pihm_pkg::ST_PULSE_OLD;
					pihm_pkg::REQ_TICK:  state_d = pihm_pkg::ST_TICK_CHK;
					default:             state_d = pihm_pkg::ST_DONE;
				endcase
			end
			pihm_pkg::ST_PULSE_OLD: state_d = pihm_pkg::ST_PULSE_MUL;
			pihm_pkg::ST_PULSE_MUL: state_d = pihm_pkg::ST_PULSE_VAR;
			pihm_pkg::ST_PULSE_VAR: state_d = pihm_pkg::ST_MEAN_DIV;
			pihm_pkg::ST_MEAN_DIV:  state_d = pihm_pkg::ST_MEAN_WAIT;
			pihm_pkg::ST_MEAN_WAIT: if (!dv_busy_q) begin
				state_d = (rec_q.fill < FILL_W'(2)) ? pihm_pkg::ST_FLOW_MUL : pihm_pkg::ST_VAR_DIV;
			end
			pihm_pkg::ST_VAR_DIV:   state_d = pihm_pkg::ST_VAR_WAIT;
			pihm_pkg::ST_VAR_WAIT:  if (!dv_busy_q) state_d = pihm_pkg::ST_SQRT_RUN;
			pihm_pkg::ST_SQRT_RUN:  if (!sq_busy_q) state_d = pihm_pkg::ST_FLOW_MUL;
			pihm_pkg::ST_FLOW_MUL: begin
				state_d = (iv_q == '0 || ppo_q == '0) ? pihm_pkg::ST_DONE : pihm_pkg::ST_FLOW_DIV;
			end
			pihm_pkg::ST_FLOW_DIV:  state_d = pihm_pkg::ST_FLOW_WAIT;
			pihm_pkg::ST_FLOW_WAIT: if (!dv_busy_q) state_d = pihm_pkg::ST_DONE;
			pihm_pkg::ST_TICK_CHK: begin
				priority if (ppo_q == uncal_rate_q)                state_d = pihm_pkg::ST_DONE;
				else if (rec_q.good == '0)                         state_d = pihm_pkg::ST_DONE;
				else if (pour_q && (elapsed_q > stuck_tmo_q))      state_d = pihm_pkg::ST_DONE;
				else if (rec_q.mean != '0)                         state_d = pihm_pkg::ST_RATIO_DIV;
				else                                               state_d = pihm_pkg::ST_SCORE_MUL;
			end
			pihm_pkg::ST_RATIO_DIV:  state_d = pihm_pkg::ST_RATIO_WAIT;
			pihm_pkg::ST_RATIO_WAIT: if (!dv_busy_q) state_d = pihm_pkg::ST_SCORE_MUL;
			pihm_pkg::ST_SCORE_MUL: begin
				state_d = (rec_q.rej >= rec_q.good) ? pihm_pkg::ST_TICK_CLASS
					: pihm_pkg::ST_SCORE_DIV;
			end
			pihm_pkg::ST_SCORE_DIV:  state_d = pihm_pkg::ST_SCORE_WAIT;
			pihm_pkg::ST_SCORE_WAIT: if (!dv_busy_q) state_d = pihm_pkg::ST_TICK_CLASS;
			pihm_pkg::ST_TICK_CLASS: state_d = pihm_pkg::ST_DONE;
			pihm_pkg::ST_DONE:       if (done_go) state_d = pihm_pkg::ST_IDLE;
			default:                 state_d = pihm_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = (state_q == pihm_pkg::ST_IDLE);
		dv_start  = 1'b0;
		dv_dvd    = '0;
		dv_dvs    = '0;
		sq_start  = (state_q == pihm_pkg::ST_VAR_WAIT) && !dv_busy_q;
		win_we    = (state_q == pihm_pkg::ST_PULSE_OLD);
		done_go   = (state_q == pihm_pkg::ST_DONE) && (!out_vld_q || rsp.ready);
		unique case (state_q)
			pihm_pkg::ST_MEAN_DIV: begin
				dv_start = 1'b1;
				dv_dvd   = pihm_pkg::DVD_W'({rec_q.sum, 4'b0});
				dv_dvs   = pihm_pkg::DVS_W'(rec_q.fill);
			end
			pihm_pkg::ST_VAR_DIV: begin
				dv_start = 1'b1;
				dv_dvd   = pihm_pkg::DVD_W'({d_q, 8'b0});
				dv_dvs   = pihm_pkg::DVS_W'(nn_q);
			end
			pihm_pkg::ST_FLOW_DIV: begin
				dv_start = 1'b1;
				dv_dvd   = pihm_pkg::DVD_W'(pihm_pkg::FLOW_NUM);
				dv_dvs   = prod_q;
			end
			pihm_pkg::ST_RATIO_DIV: begin
				dv_start = 1'b1;
				dv_dvd   = pihm_pkg::DVD_W'({rec_q.spread, 8'b0});
				dv_dvs   = pihm_pkg::DVS_W'(rec_q.mean);
			end
			pihm_pkg::ST_SCORE_DIV: begin
				dv_start = 1'b1;
				dv_dvd   = pihm_pkg::DVD_W'(sm_q);
				dv_dvs   = rec_q.good;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pihm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// memories: record read at acceptance, written when the report enters the output register
	always_ff @(posedge clk) begin
		if (acc) chan_rd_q <= chan_mem[rd_idx];
		if (done_go) chan_mem[ch_idx] <= rec_q;
		if (state_q == pihm_pkg::ST_REC) win_rd_q <= win_mem[win_addr];
		if (win_we) win_mem[win_addr_q] <= iv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (acc) rd_vld_q <= rec_vld_q[rd_idx];
			if (done_go) rec_vld_q[ch_idx] <= 1'b1;
		end
	end

	// shared restoring divider, one quotient bit a cycle
	assign dv_sh  = {dv_rem_q, dv_num_q[pihm_pkg::DVD_W-1]};
	assign dv_fit = dv_sh >= {1'b0, dv_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (dv_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= pihm_pkg::DCNT_W'(pihm_pkg::DVD_W - 1);
		end else if (dv_busy_q) begin
			if (dv_cnt_q == '0) dv_busy_q <= 1'b0;
			else                dv_cnt_q  <= dv_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_start) begin
			dv_num_q <= dv_dvd;
			dv_den_q <= dv_dvs;
			dv_rem_q <= '0;
		end else if (dv_busy_q) begin
			dv_rem_q <= dv_fit ? pihm_pkg::DVS_W'(dv_sh - {1'b0, dv_den_q})
				: dv_sh[pihm_pkg::DVS_W-1:0];
			dv_num_q <= {dv_num_q[pihm_pkg::DVD_W-2:0], dv_fit};
		end
	end

	// digit-by-digit square root of the divider quotient
	assign sq_sh    = {sq_rem_q[31:0], sq_x_q[pihm_pkg::DVD_W-1 -: 2]};
	assign sq_trial = {sq_root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (sq_start) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= pihm_pkg::SCNT_W'(pihm_pkg::SQ_STEPS - 1);
		end else if (sq_busy_q) begin
			if (sq_cnt_q == '0) sq_busy_q <= 1'b0;
			else                sq_cnt_q  <= sq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sq_start) begin
			sq_x_q    <= dv_num_q;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_x_q <= {sq_x_q[pihm_pkg::DVD_W-3:0], 2'b00};
			if (sq_sh >= sq_trial) begin
				sq_rem_q  <= sq_sh - sq_trial;
				sq_root_q <= {sq_root_q[30:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_sh;
				sq_root_q <= {sq_root_q[30:0], 1'b0};
			end
		end
	end

	// datapath: record update by step
	always_ff @(posedge clk) begin
		if (acc) begin
			type_q    <= req.req_type;
			ch_q      <= req.channel;
			iv_q      <= req.interval_ms;
			ppo_q     <= req.pulses_per_oz;
			pour_q    <= req.pouring;
			elapsed_q <= req.pour_elapsed_ms;
		end
		unique case (state_q)
			pihm_pkg::ST_REC: begin
				rec_q      <= rec_init;
				win_addr_q <= win_addr;
			end
			pihm_pkg::ST_PULSE_OLD: begin
				// full window: the entry being overwritten leaves the sums
				if (rec_q.fill >= FILL_W'(WINDOW_DEPTH)) begin
					rec_q.sum <= rec_q.sum - SUM_W'(win_rd_q) + SUM_W'(iv_q);
					rec_q.sq  <= rec_q.sq - SQ_W'(old_sq) + SQ_W'(new_sq);
				end else begin
					rec_q.fill <= rec_q.fill + 1'b1;
					rec_q.sum  <= rec_q.sum + SUM_W'(iv_q);
					rec_q.sq   <= rec_q.sq + SQ_W'(new_sq);
				end
				rec_q.slot <= (rec_q.slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
					: rec_q.slot + 1'b1;
			end
			pihm_pkg::ST_PULSE_MUL: begin
				nsq_q <= NSQ_W'(rec_q.fill) * NSQ_W'(rec_q.sq);
				s2_q  <= S2_W'(rec_q.sum) * S2_W'(rec_q.sum);
			end
			pihm_pkg::ST_PULSE_VAR: begin
				d_q  <= (S2_W'(nsq_q) > s2_q) ? NSQ_W'(S2_W'(nsq_q) - s2_q) : '0;
				nn_q <= (2*FILL_W)'(rec_q.fill) * (2*FILL_W)'(rec_q.fill);
			end
			pihm_pkg::ST_MEAN_WAIT: if (!dv_busy_q) begin
				rec_q.mean <= dv_num_q[19:0];
				if (rec_q.fill < FILL_W'(2)) rec_q.spread <= '0;
			end
			pihm_pkg::ST_SQRT_RUN: if (!sq_busy_q) rec_q.spread <= sq_root_q[19:0];
			pihm_pkg::ST_FLOW_MUL: prod_q <= 32'(iv_q) * 32'(ppo_q);
			pihm_pkg::ST_FLOW_WAIT: if (!dv_busy_q) begin
				rec_q.flow <= (dv_num_q > pihm_pkg::DVD_W'(pihm_pkg::FLOW_MAX))
					? pihm_pkg::FLOW_MAX : dv_num_q[15:0];
			end
			pihm_pkg::ST_TICK_CHK: begin
				ratio_q <= '0;
				priority if (ppo_q == uncal_rate_q) begin
					rec_q.health  <= pihm_pkg::HEALTH_CALIB;
					rec_q.quality <= pihm_pkg::CAL_QUALITY;
				end else if (rec_q.good == '0) begin
					rec_q.health  <= pihm_pkg::HEALTH_NOSIG;
					rec_q.quality <= '0;
				end else if (pour_q && (elapsed_q > stuck_tmo_q)) begin
					rec_q.health  <= pihm_pkg::HEALTH_STUCK;
					rec_q.quality <= pihm_pkg::STUCK_QUALITY;
				end else begin
				end
			end
			pihm_pkg::ST_RATIO_WAIT: if (!dv_busy_q) ratio_q <= dv_num_q[27:0];
			pihm_pkg::ST_SCORE_MUL: begin
				score_q <= '0;
				sm_q    <= 47'(pihm_pkg::SCORE_FULL) * 47'(rec_q.good - rec_q.rej);
			end
			pihm_pkg::ST_SCORE_WAIT: if (!dv_busy_q) score_q <= dv_num_q[14:0];
			pihm_pkg::ST_TICK_CLASS: begin
				if (ratio_q > 28'(noise_lim_q) || score_q < {min_score_q, 8'b0}) begin
					rec_q.health  <= pihm_pkg::HEALTH_NOISY;
					rec_q.quality <= score_q >> 1;
				end else begin
					rec_q.health  <= pihm_pkg::HEALTH_GOOD;
					rec_q.quality <= (pen >= 33'(score_q)) ? '0 : 15'(33'(score_q) - pen);
				end
			end
			default: ;
		endcase
	end

	// output register: the next request may enter while a report waits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (done_go) out_vld_q <= 1'b1;
		else if (rsp.ready) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_rec_q <= rec_q;
			out_ch_q  <= ch_q;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.out_channel     = out_ch_q;
	assign rsp.health          = out_rec_q.health;
	assign rsp.quality         = out_rec_q.quality;
	assign rsp.mean_interval   = out_rec_q.mean;
	assign rsp.interval_spread = out_rec_q.spread;
	assign rsp.flow_rate       = out_rec_q.flow;
	assign rsp.good_pulses     = out_rec_q.good;
	assign rsp.rejected_pulses = out_rec_q.rej;

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pihm_pkg::ST_IDLE) |-> (!dv_busy_q && !sq_busy_q))
		else $error("arithmetic unit busy while idle");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		done_go |-> (rec_q.fill <= FILL_W'(WINDOW_DEPTH)))
		else $error("window fill beyond depth");
	a_health_rng: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.health <= pihm_pkg::HEALTH_CALIB && rsp.quality <= pihm_pkg::SCORE_FULL))
		else $error("report out of range");
	a_win_slot: assert property (@(posedge clk) disable iff (!arst_n)
		win_we |-> (rec_q.slot <= SLOT_W'(WINDOW_DEPTH - 1)))
		else $error("window slot out of range");
`endif

endmodule
